// File: rtl/core/cosine_joint_trajectory_assert.svh
// ----------------------------------------------------------------------------
// cosine joint trajectory assertion macros
// immediate-consequence and next-cycle property forms on clk with reset gating
// ----------------------------------------------------------------------------
`ifndef COSINE_JOINT_TRAJECTORY_ASSERT_SVH
`define COSINE_JOINT_TRAJECTORY_ASSERT_SVH

// same-cycle implication
`define CJT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CJT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/cjt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cjt_pkg
// shared constants and types of the cosine joint trajectory block
// ----------------------------------------------------------------------------
package cjt_pkg;

	localparam int CJT_JOINTS = 16;
	localparam int CJT_ENTRIES = 256;

	localparam int PROG_W = 17;
	localparam int ANGLE_W = 16;

	localparam logic [PROG_W-1:0] FULL_SCALE = 17'h10000;
	localparam logic [PROG_W-1:0] STEP_RESET = 17'd655;
	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	typedef enum logic [1:0] {
		PH_HOME  = 2'd0,
		PH_STAND = 2'd1,
		PH_HOLD  = 2'd2
	} phase_t;

endpackage

// File: rtl/core/cjt_weight_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cjt_weight_rom
// constant table of (1 - cos(pi*x))/2 in Q16, built at elaboration
// ----------------------------------------------------------------------------
module cjt_weight_rom import cjt_pkg::*; #(
	parameter int ENTRIES = CJT_ENTRIES
) (
	input  logic [$clog2(ENTRIES+1)-1:0] addr,
	output logic [PROG_W-1:0]            weight
);

	logic [PROG_W-1:0] rom [ENTRIES+1];

	// q30 taylor sine up to the ninth power, squared down to q16
	function automatic logic [PROG_W-1:0] sine_sq(input logic [63:0] th);
		logic [63:0] t2;
		logic [63:0] term;
		logic [63:0] s;
		logic [63:0] sq;
		begin
			t2 = (th * th) >> 30;
			term = th;
			s = th;
			term = ((term * t2) >> 30) / 64'd6;
			s = s - term;
			term = ((term * t2) >> 30) / 64'd20;
			s = s + term;
			term = ((term * t2) >> 30) / 64'd42;
			s = s - term;
			term = ((term * t2) >> 30) / 64'd72;
			s = s + term;
			sq = (s * s + (64'd1 << 43)) >> 44;
			sine_sq = sq[PROG_W-1:0];
		end
	endfunction

	for (genvar g = 0; g <= ENTRIES; g++) begin : g_rom
		localparam int K = (2 * g <= ENTRIES) ? g : ENTRIES - g;
		localparam logic [63:0] TH = (PI_Q30 * 64'(K)) / (64'd2 * 64'(ENTRIES));
		if (2 * g <= ENTRIES) begin : g_lo
			assign rom[g] = sine_sq(TH);
		end else begin : g_hi
			assign rom[g] = FULL_SCALE - sine_sq(TH);
		end
	end

	assign weight = rom[addr];

endmodule

// File: rtl/core/cjt_profile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cjt_profile
// cosine blend from start to target at a q16 progress, rounded to nearest
// ----------------------------------------------------------------------------
module cjt_profile import cjt_pkg::*; #(
	parameter int ENTRIES = CJT_ENTRIES
) (
	input  logic signed [ANGLE_W-1:0] start,
	input  logic signed [ANGLE_W-1:0] target,
	input  logic [PROG_W-1:0]         progress,
	output logic signed [ANGLE_W-1:0] cmd
);

	localparam int XW = $clog2(ENTRIES + 1);
	localparam int SW = PROG_W + XW;

	logic [SW-1:0]           scaled;
	logic [XW:0]             idx_wide;
	logic [XW-1:0]           idx;
	logic [PROG_W-1:0]       weight;
	logic signed [16:0]      diff;
	logic signed [34:0]      prod;
	logic signed [34:0]      rounded;
	logic [ANGLE_W-1:0]      delta;

	assign scaled = SW'(progress) * SW'(ENTRIES);
	assign idx_wide = scaled[SW-1:16];
	assign idx = (idx_wide > (XW+1)'(ENTRIES)) ? XW'(ENTRIES) : idx_wide[XW-1:0];

	cjt_weight_rom #(
		.ENTRIES(ENTRIES)
	) u_rom (
		.addr  (idx),
		.weight(weight)
	);

	assign diff = 17'(target) - 17'(start);
	assign prod = 35'(diff) * 35'($signed({1'b0, weight}));
	assign rounded = prod + 35'sd32768;
	// result stays between start and target, so the low bits carry it
	assign delta = rounded[31:16];
	assign cmd = start + $signed(delta);

endmodule

// File: rtl/core/cosine_joint_trajectory.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_joint_trajectory
// homing then stand-up joint commands along a cosine blend, then hold
// result beat reaches the outputs through the input register, then the result
// register; one item per cycle while res_ready does not stall the result, the
// progress registers are read and updated within the single compute stage
// reset clears pipeline valids, progress and the step register (655);
// per-joint start and held stores are not cleared
// ----------------------------------------------------------------------------
module cosine_joint_trajectory import cjt_pkg::*; #(
	parameter int JOINTS = CJT_JOINTS,
	parameter int WEIGHT_TABLE_ENTRIES = CJT_ENTRIES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_ready,
	input  logic                      restart,
	input  logic [3:0]                joint_index,
	input  logic signed [ANGLE_W-1:0] measured_position,
	input  logic signed [ANGLE_W-1:0] home_position,
	input  logic signed [ANGLE_W-1:0] stand_position,
	input  logic                      last_joint,
	output logic                      res_valid,
	input  logic                      res_ready,
	output logic [3:0]                out_joint_index,
	output logic signed [ANGLE_W-1:0] command_position,
	output logic [1:0]                phase,
	output logic                      done_res,
	output logic                      out_last_joint,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [PROG_W-1:0]         cfg_data
);

	localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

	// input stage
	logic                      valid_s1;
	logic                      restart_s1;
	logic [3:0]                joint_index_s1;
	logic signed [ANGLE_W-1:0] meas_s1;
	logic signed [ANGLE_W-1:0] home_s1;
	logic signed [ANGLE_W-1:0] stand_s1;
	logic                      last_s1;

	// block state
	logic [PROG_W-1:0]         step_q;
	logic [PROG_W-1:0]         home_prog_q;
	logic [PROG_W-1:0]         stand_prog_q;
	logic signed [ANGLE_W-1:0] start_q [JOINTS];
	logic signed [ANGLE_W-1:0] held_q [JOINTS];

	// result register
	logic                      res_valid_q;
	logic [3:0]                joint_index_q;
	logic signed [ANGLE_W-1:0] cmd_q;
	phase_t                    phase_q;
	logic                      last_q;

	logic                      out_free;
	logic                      adv;
	logic                      in_range;
	logic [JW-1:0]             jsel;
	logic [PROG_W-1:0]         home_eff;
	logic [PROG_W-1:0]         stand_eff;
	logic                      home_act;
	logic                      stand_act;
	phase_t                    ph;
	logic                      capture;
	logic signed [ANGLE_W-1:0] start_eff;
	logic signed [ANGLE_W-1:0] target;
	logic [PROG_W-1:0]         prog_sel;
	logic [PROG_W:0]           prog_sum;
	logic [PROG_W-1:0]         prog_next;
	logic signed [ANGLE_W-1:0] prof_cmd;
	logic signed [ANGLE_W-1:0] held_rd;
	logic signed [ANGLE_W-1:0] cmd;

	assign out_free = !res_valid_q || res_ready;
	assign adv = valid_s1 && out_free;
	assign item_ready = !valid_s1 || out_free;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			restart_s1 <= restart;
			joint_index_s1 <= joint_index;
			meas_s1 <= measured_position;
			home_s1 <= home_position;
			stand_s1 <= stand_position;
			last_s1 <= last_joint;
		end
	end

	// compute stage
	assign in_range = 32'(joint_index_s1) < JOINTS;
	assign jsel = JW'(32'(joint_index_s1));

	assign home_eff = restart_s1 ? '0 : home_prog_q;
	assign stand_eff = restart_s1 ? '0 : stand_prog_q;
	assign home_act = !home_eff[PROG_W-1];
	assign stand_act = !home_act && !stand_eff[PROG_W-1];

	always_comb begin
		if (home_act) begin
			ph = PH_HOME;
		end else if (stand_act) begin
			ph = PH_STAND;
		end else begin
			ph = PH_HOLD;
		end
	end

	// restart, or first tick of the stand phase, takes the measured angle
	assign capture = restart_s1 || (stand_act && stand_eff == '0);
	assign start_eff = !in_range ? '0 : (capture ? meas_s1 : start_q[jsel]);
	assign target = home_act ? home_s1 : stand_s1;
	assign prog_sel = home_act ? home_eff : stand_eff;

	assign prog_sum = {1'b0, prog_sel} + {1'b0, step_q};
	assign prog_next = (prog_sum > {1'b0, FULL_SCALE}) ? FULL_SCALE : prog_sum[PROG_W-1:0];

	cjt_profile #(
		.ENTRIES(WEIGHT_TABLE_ENTRIES)
	) u_profile (
		.start   (start_eff),
		.target  (target),
		.progress(prog_sel),
		.cmd     (prof_cmd)
	);

	assign held_rd = in_range ? held_q[jsel] : '0;
	assign cmd = (ph == PH_HOLD) ? held_rd : prof_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (cfg_valid) begin
			step_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			home_prog_q <= '0;
			stand_prog_q <= '0;
		end else if (adv) begin
			home_prog_q <= (home_act && last_s1) ? prog_next : home_eff;
			stand_prog_q <= (stand_act && last_s1) ? prog_next : stand_eff;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_range) begin
			if (capture) begin
				start_q[jsel] <= start_eff;
			end
			held_q[jsel] <= cmd;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			joint_index_q <= joint_index_s1;
			cmd_q <= cmd;
			phase_q <= ph;
			last_q <= last_s1;
		end
	end

	assign res_valid = res_valid_q;
	assign out_joint_index = joint_index_q;
	assign command_position = cmd_q;
	assign phase = phase_q;
	assign done_res = (phase_q == PH_HOLD);
	assign out_last_joint = last_q;

endmodule

// File: rtl/core/cjt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cjt_checker
// port-level checks of the cosine joint trajectory, bound to the top level
// ----------------------------------------------------------------------------
`include "cosine_joint_trajectory_assert.svh"

module cjt_checker import cjt_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      res_valid,
	input logic                      res_ready,
	input logic [3:0]                out_joint_index,
	input logic signed [ANGLE_W-1:0] command_position,
	input logic [1:0]                phase,
	input logic                      done_res,
	input logic                      out_last_joint
);

	logic       seen_q;
	logic [1:0] prev_phase_q;
	logic       prev_last_q;
	logic       beat;
	logic       done_ok;
	logic       stalled;
	logic       went_back;
	logic       moved;
	logic [ANGLE_W+8-1:0] res_bus;

	assign beat = res_valid && res_ready;
	assign done_ok = (done_res == (phase == PH_HOLD));
	assign stalled = res_valid && !res_ready;
	assign went_back = beat && seen_q && (phase < prev_phase_q);
	assign moved = beat && seen_q && (phase != prev_phase_q);
	assign res_bus = {out_joint_index, command_position, phase, done_res, out_last_joint};

	// phase and end-of-tick flag of the previous delivered beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			prev_phase_q <= PH_HOME;
			prev_last_q <= 1'b0;
		end else if (beat) begin
			seen_q <= 1'b1;
			prev_phase_q <= phase;
			prev_last_q <= out_last_joint;
		end
	end

	`CJT_ASSERT_NOW(a_done_matches_phase, res_valid, done_ok, "done flag disagrees with phase")
	`CJT_ASSERT_NEXT(a_stall_holds, stalled, res_valid && $stable(res_bus), "beat changed while stalled")
	`CJT_ASSERT_NOW(a_phase_back_only_home, went_back, phase == PH_HOME, "phase went back past homing")
	`CJT_ASSERT_NOW(a_phase_step_at_tick, moved, prev_last_q || phase == PH_HOME, "phase moved inside a tick")

endmodule

bind cosine_joint_trajectory cjt_checker u_cjt_checker (.*);
